/* hdl/lowest_free_slot_interval_allocator_defines.svh */
// Assertion macros used by the allocator's top-level RTL file.
`ifndef LOWEST_FREE_SLOT_INTERVAL_ALLOCATOR_DEFINES_SVH
`define LOWEST_FREE_SLOT_INTERVAL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define LFSIA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset as well.
`define LFSIA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/lfsia_pkg.sv */
// Package with the shared constants and types of the slot allocator.
package lfsia_pkg;

  localparam int NUM_SLOTS_DEF  = 64;
  localparam int COUNT_BITS_DEF = 20;
  localparam int TIME_BITS      = 32;

  // One job request as it travels down the row of cells.
  typedef struct packed {
    logic                 restart;
    logic [TIME_BITS-1:0] end_time;
    logic [TIME_BITS-1:0] start_time;
  } req_t;

endpackage

/* hdl/lfsia_cell.sv */
// One slot cell of the allocator row: holds a slot and passes each request on.
module lfsia_cell
  import lfsia_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int SLOT_BITS  = 6,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  req_t                  in_req,
  input  logic                  in_found,
  input  logic [SLOT_BITS-1:0]  in_slot,
  input  logic [COUNT_BITS-1:0] in_uses,
  output logic                  out_valid,
  output req_t                  out_req,
  output logic                  out_found,
  output logic [SLOT_BITS-1:0]  out_slot,
  output logic [COUNT_BITS-1:0] out_uses
);

  logic                  busy;
  logic [TIME_BITS-1:0]  end_reg;
  logic [COUNT_BITS-1:0] count;

  logic                  busy_now;
  logic [COUNT_BITS-1:0] count_now;
  logic                  expired;
  logic                  claim;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  busy_next;
  logic [COUNT_BITS-1:0] count_next;

  always_comb begin
    // A restart empties the slot before the freeing rule is applied.
    busy_now   = busy && !in_req.restart;
    count_now  = in_req.restart ? '0 : count;
    expired    = end_reg <= in_req.start_time;
    claim      = !in_found && (!busy_now || expired);
    count_inc  = (count_now == '1) ? count_now : count_now + 1'b1;
    busy_next  = claim || (busy_now && !expired);
    count_next = claim ? count_inc : count_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (en && in_valid) begin
      busy  <= busy_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid && claim) begin
      end_reg <= in_req.end_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_req   <= in_req;
      out_found <= in_found || claim;
      out_slot  <= claim ? SLOT_BITS'(INDEX) : in_slot;
      out_uses  <= claim ? count_inc : in_uses;
    end
  end

endmodule

/* hdl/lowest_free_slot_interval_allocator.sv */
// Lowest-free-slot interval allocator: top level with the row of slot cells.
//
// Requests enter on the s_ channel: start and end time in s_tdata, restart in
// s_tuser. Each request gets the lowest-numbered slot that is free once every
// slot whose end time is at or before the start time has been released. The
// m_ channel returns the slot index and its updated use count in m_tdata and
// a full flag in m_tuser; a full result carries slot 0 and count 0.
// The slots form a row of NUM_SLOTS cells. A request moves one cell per cycle
// while the row is not frozen, and each cell frees, clears or claims its own
// slot as the request passes; the result comes from the last cell's registers.
// Requests follow each other at one per cycle, limited only by the output side.
// Reset empties every slot and zeroes every count.
// When the receiver holds m_tready low with a result waiting, the whole row
// freezes and s_tready falls until that result is taken; no request is lost.
module lowest_free_slot_interval_allocator
  import lfsia_pkg::*;
#(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [63:0]         s_tdata,  // start_time[31:0], end_time[63:32]
  input  logic [0:0]          s_tuser,  // restart
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [((($clog2(NUM_SLOTS) + COUNT_BITS) + 7) / 8) * 8 - 1:0]
                              m_tdata,  // slot, slot_uses, zero fill
  output logic [0:0]          m_tuser   // full_res
);

  `include "lowest_free_slot_interval_allocator_defines.svh"

  localparam int SLOT_BITS = $clog2(NUM_SLOTS);
  localparam int OUT_BITS  = ((SLOT_BITS + COUNT_BITS + 7) / 8) * 8;

  logic                  stage_valid [NUM_SLOTS+1];
  req_t                  stage_req   [NUM_SLOTS+1];
  logic                  stage_found [NUM_SLOTS+1];
  logic [SLOT_BITS-1:0]  stage_slot  [NUM_SLOTS+1];
  logic [COUNT_BITS-1:0] stage_uses  [NUM_SLOTS+1];

  logic advance;
  logic full_res;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  always_comb begin
    stage_valid[0]          = s_tvalid;
    stage_req[0].start_time = s_tdata[31:0];
    stage_req[0].end_time   = s_tdata[63:32];
    stage_req[0].restart    = s_tuser[0];
    stage_found[0]          = 1'b0;
    stage_slot[0]           = '0;
    stage_uses[0]           = '0;
  end

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    lfsia_cell #(
      .INDEX      (k),
      .SLOT_BITS  (SLOT_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (stage_valid[k]),
      .in_req    (stage_req[k]),
      .in_found  (stage_found[k]),
      .in_slot   (stage_slot[k]),
      .in_uses   (stage_uses[k]),
      .out_valid (stage_valid[k+1]),
      .out_req   (stage_req[k+1]),
      .out_found (stage_found[k+1]),
      .out_slot  (stage_slot[k+1]),
      .out_uses  (stage_uses[k+1])
    );
  end

  assign full_res = !stage_found[NUM_SLOTS];
  assign m_tvalid = stage_valid[NUM_SLOTS];
  assign m_tdata  = OUT_BITS'({stage_uses[NUM_SLOTS], stage_slot[NUM_SLOTS]});
  assign m_tuser  = full_res;

  `LFSIA_ASSERT_NOW(a_full_is_empty, m_tvalid && full_res,
    stage_slot[NUM_SLOTS] == '0 && stage_uses[NUM_SLOTS] == '0,
    "full result carries a slot or a count")
  `LFSIA_ASSERT_NOW(a_uses_nonzero, m_tvalid && !full_res,
    stage_uses[NUM_SLOTS] != '0, "assigned slot reports a zero use count")
  `LFSIA_ASSERT_NOW(a_slot_in_range, m_tvalid && !full_res,
    32'(stage_slot[NUM_SLOTS]) < NUM_SLOTS, "assigned slot beyond the row")
  `LFSIA_ASSERT_NEXT(a_reset_empty, rst, !m_tvalid,
    "result pending straight after reset")

endmodule
